// ----- design/xbt_pkg.sv -----
package xbt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CAPACITY_DEF   = 1024;

    localparam logic [3:0] OP_INSERT   = 4'd0;
    localparam logic [3:0] OP_ERASE    = 4'd1;
    localparam logic [3:0] OP_XOR_ALL  = 4'd2;
    localparam logic [3:0] OP_MIN_XOR  = 4'd3;
    localparam logic [3:0] OP_MAX_XOR  = 4'd4;
    localparam logic [3:0] OP_KTH      = 4'd5;
    localparam logic [3:0] OP_COUNT_LT = 4'd6;
    localparam logic [3:0] OP_COUNT_LE = 4'd7;
    localparam logic [3:0] OP_COUNT_EQ = 4'd8;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_ERASE_ABSENT = 3'd1;
    localparam logic [2:0] ST_SET_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RANK_RANGE   = 3'd3;
    localparam logic [2:0] ST_SET_FULL     = 3'd4;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] operand_value;
        logic [9:0]  rank_index;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_value;
        logic [10:0] result_count;
        logic [10:0] element_count;
        logic [2:0]  status;
    } t_out_beat;

endpackage

// ----- design/xor_binary_trie_multiset.sv -----
// Each beat walks the node store one trie level at a time; insert allocates missing
// nodes on the way, kth may read a second child at a level, and erase walks twice
// (find, then decrement). xor_all and early-out cases skip the walk. One beat in
// flight: a new beat is taken only once the previous result is in the output register.
// Reset clears control state only; node memories are not cleared and the free list
// is tracked with a low-water mark, so no clearing pass runs after reset.
module xor_binary_trie_multiset #(
    parameter int VALUE_BITS = xbt_pkg::VALUE_BITS_DEF,
    parameter int CAPACITY   = xbt_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  xbt_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output xbt_pkg::t_out_beat o_out_data
);

    localparam int POOL = CAPACITY * VALUE_BITS + 1;
    localparam int IW   = $clog2(POOL + 1);
    localparam int AW   = $clog2(POOL);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LW   = $clog2(VALUE_BITS + 1);
    localparam int KW   = (CW > 10) ? CW : 10;
    localparam int NW   = CW + 2 * IW;
    localparam logic [IW-1:0] NIL = IW'(POOL);
    localparam logic [LW-1:0] TOP_LVL = LW'(VALUE_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_AROOT = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    logic [NW-1:0] m_node [POOL];
    logic [IW-1:0] m_free [POOL];

    t_state              r_state, n_state;
    logic [3:0]          r_op, n_op;
    logic [VALUE_BITS-1:0] r_v, n_v;
    logic [VALUE_BITS-1:0] r_mask, n_mask;
    logic [VALUE_BITS-1:0] r_res, n_res;
    logic [KW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_rcnt, n_rcnt;
    logic [CW-1:0]       r_sum, n_sum;
    logic [CW-1:0]       r_size, n_size;
    logic [2:0]          r_status, n_status;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [IW-1:0]       r_node, n_node;
    logic [IW-1:0]       r_alt, n_alt;
    logic [IW-1:0]       r_root, n_root;
    logic [IW-1:0]       r_top, n_top;
    logic [IW-1:0]       r_min_top, n_min_top;
    logic                r_fresh, n_fresh;
    logic                r_probe, n_probe;
    logic                r_addp, n_addp;
    logic                r_erasing, n_erasing;
    logic                r_pw, n_pw;
    logic                r_ps, n_ps;
    logic [IW-1:0]       r_paddr, n_paddr;
    logic [CW-1:0]       r_pcnt, n_pcnt;
    logic [IW-1:0]       r_pch0, n_pch0;
    logic [IW-1:0]       r_pch1, n_pch1;
    logic                r_out_valid, n_out_valid;
    xbt_pkg::t_out_beat  r_out, n_out;

    logic [NW-1:0] r_rd_data;
    logic [IW-1:0] r_fl_data;

    logic          nd_rd_en, nd_wr_en, fl_rd_en, fl_wr_en;
    logic [IW-1:0] nd_rd_addr, nd_wr_addr, fl_wr_data;
    logic [NW-1:0] nd_wr_data;

    logic [CW-1:0] cur_cnt, cnt_inc, cnt_dec, sum_now;
    logic [IW-1:0] cur_ch0, cur_ch1, c_e, c_o, c0, c1, alloc_idx, new_node;
    logic [LW-1:0] bpos;
    logic [VALUE_BITS-1:0] sh_v, sh_m, bit1, in_v;
    logic          vb, mb, accept, out_free;

    always_comb begin
        cur_cnt  = r_fresh ? '0  : r_rd_data[NW-1 -: CW];
        cur_ch1  = r_fresh ? NIL : r_rd_data[2*IW-1:IW];
        cur_ch0  = r_fresh ? NIL : r_rd_data[IW-1:0];
        cnt_inc  = CW'(cur_cnt + 1'b1);
        cnt_dec  = CW'(cur_cnt - 1'b1);
        bpos     = LW'(r_lvl - 1'b1);
        sh_v     = r_v >> bpos;
        sh_m     = r_mask >> bpos;
        vb       = sh_v[0];
        mb       = sh_m[0];
        bit1     = VALUE_BITS'(1) << bpos;
        c_e      = (vb ^ mb) ? cur_ch1 : cur_ch0;
        c_o      = (vb ^ mb) ? cur_ch0 : cur_ch1;
        c0       = mb ? cur_ch1 : cur_ch0;
        c1       = mb ? cur_ch0 : cur_ch1;
        sum_now  = r_addp ? CW'(r_sum + r_pcnt - cur_cnt) : r_sum;
        alloc_idx = IW'(r_top - 1'b1);
        new_node = (alloc_idx < r_min_top) ? alloc_idx : r_fl_data;
        in_v     = VALUE_BITS'(i_in_data.operand_value);
        accept   = i_in_valid && (r_state == S_IDLE);
        out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_v = r_v;         n_mask = r_mask;
        n_res = r_res;       n_k = r_k;         n_rcnt = r_rcnt;   n_sum = r_sum;
        n_size = r_size;     n_status = r_status; n_lvl = r_lvl;   n_node = r_node;
        n_alt = r_alt;       n_root = r_root;   n_top = r_top;     n_min_top = r_min_top;
        n_fresh = r_fresh;   n_probe = r_probe; n_addp = r_addp;   n_erasing = r_erasing;
        n_pw = r_pw;         n_ps = r_ps;       n_paddr = r_paddr; n_pcnt = r_pcnt;
        n_pch0 = r_pch0;     n_pch1 = r_pch1;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        nd_rd_en = 1'b0;     nd_rd_addr = r_root;
        nd_wr_en = 1'b0;     nd_wr_addr = r_node;  nd_wr_data = {cnt_inc, cur_ch1, cur_ch0};
        fl_rd_en = 1'b0;     fl_wr_en = 1'b0;      fl_wr_data = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_in_data.opcode;
                    n_v = in_v;
                    n_k = KW'(i_in_data.rank_index);
                    n_res = '0;
                    n_rcnt = '0;
                    n_sum = '0;
                    n_status = xbt_pkg::ST_OK;
                    n_lvl = TOP_LVL;
                    n_node = r_root;
                    n_fresh = 1'b0;
                    n_probe = 1'b0;
                    n_addp = 1'b0;
                    n_erasing = 1'b0;
                    n_pw = 1'b0;
                    n_state = S_DONE;
                    unique case (i_in_data.opcode)
                        xbt_pkg::OP_INSERT: begin
                            if (CW'(CAPACITY) <= r_size) begin
                                n_status = xbt_pkg::ST_SET_FULL;
                            end else begin
                                n_size = CW'(r_size + 1'b1);
                                if (r_root != NIL) begin
                                    nd_rd_en = 1'b1;
                                    n_state = S_WALK;
                                end else begin
                                    fl_rd_en = 1'b1;
                                    n_state = S_AROOT;
                                end
                            end
                        end
                        xbt_pkg::OP_ERASE: begin
                            if (r_root == NIL) begin
                                n_status = xbt_pkg::ST_ERASE_ABSENT;
                            end else begin
                                nd_rd_en = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        xbt_pkg::OP_XOR_ALL: begin
                            n_mask = r_mask ^ in_v;
                        end
                        xbt_pkg::OP_MIN_XOR, xbt_pkg::OP_MAX_XOR: begin
                            if (r_root == NIL) begin
                                n_status = xbt_pkg::ST_SET_EMPTY;
                            end else begin
                                if (i_in_data.opcode == xbt_pkg::OP_MAX_XOR) n_v = ~in_v;
                                nd_rd_en = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        xbt_pkg::OP_KTH: begin
                            if (r_root == NIL) begin
                                n_status = xbt_pkg::ST_SET_EMPTY;
                            end else if (KW'(i_in_data.rank_index) >= KW'(r_size)) begin
                                n_status = xbt_pkg::ST_RANK_RANGE;
                            end else begin
                                nd_rd_en = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        xbt_pkg::OP_COUNT_LT, xbt_pkg::OP_COUNT_EQ: begin
                            if (r_root != NIL) begin
                                nd_rd_en = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        xbt_pkg::OP_COUNT_LE: begin
                            if (&in_v) begin
                                n_rcnt = r_size;
                            end else begin
                                n_v = VALUE_BITS'(in_v + 1'b1);
                                if (r_root != NIL) begin
                                    nd_rd_en = 1'b1;
                                    n_state = S_WALK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_AROOT: begin
                n_root = new_node;
                n_node = new_node;
                n_top = alloc_idx;
                if (alloc_idx < r_min_top) n_min_top = alloc_idx;
                n_fresh = 1'b1;
                n_state = S_WALK;
            end

            S_ALLOC: begin
                nd_wr_en = 1'b1;
                nd_wr_data = (vb ^ mb) ? {cnt_inc, new_node, cur_ch0}
                                       : {cnt_inc, cur_ch1, new_node};
                n_top = alloc_idx;
                if (alloc_idx < r_min_top) n_min_top = alloc_idx;
                n_node = new_node;
                n_fresh = 1'b1;
                n_lvl = LW'(r_lvl - 1'b1);
                n_state = S_WALK;
            end

            S_FLUSH: begin
                nd_wr_en = 1'b1;
                nd_wr_addr = r_paddr;
                nd_wr_data = {r_pcnt, r_pch1, r_pch0};
                n_state = S_DONE;
            end

            S_WALK: begin
                nd_rd_addr = c_e;
                priority if (r_op == xbt_pkg::OP_INSERT) begin
                    if (r_lvl == '0) begin
                        nd_wr_en = 1'b1;
                        n_state = S_DONE;
                    end else if (c_e != NIL) begin
                        nd_wr_en = 1'b1;
                        nd_rd_en = 1'b1;
                        n_node = c_e;
                        n_fresh = 1'b0;
                        n_lvl = LW'(r_lvl - 1'b1);
                    end else begin
                        fl_rd_en = 1'b1;
                        n_state = S_ALLOC;
                    end
                end else if (r_op == xbt_pkg::OP_ERASE && r_erasing) begin
                    if (r_pw) begin
                        nd_wr_en = 1'b1;
                        nd_wr_addr = r_paddr;
                        nd_wr_data = {r_pcnt,
                                      (r_ps && cur_cnt == CW'(1)) ? NIL : r_pch1,
                                      (!r_ps && cur_cnt == CW'(1)) ? NIL : r_pch0};
                    end
                    if (cur_cnt == CW'(1)) begin
                        fl_wr_en = 1'b1;
                        n_top = IW'(r_top + 1'b1);
                        if (r_lvl == TOP_LVL) n_root = NIL;
                    end
                    n_pw = 1'b1;
                    n_paddr = r_node;
                    n_pcnt = cnt_dec;
                    n_pch0 = cur_ch0;
                    n_pch1 = cur_ch1;
                    n_ps = vb ^ mb;
                    if (r_lvl == '0) begin
                        n_state = S_FLUSH;
                    end else begin
                        nd_rd_en = 1'b1;
                        n_node = c_e;
                        n_lvl = LW'(r_lvl - 1'b1);
                    end
                end else if (r_op == xbt_pkg::OP_ERASE || r_op == xbt_pkg::OP_COUNT_EQ) begin
                    if (r_lvl == '0) begin
                        if (r_op == xbt_pkg::OP_COUNT_EQ) begin
                            n_rcnt = cur_cnt;
                            n_state = S_DONE;
                        end else begin
                            nd_rd_en = 1'b1;
                            nd_rd_addr = r_root;
                            n_node = r_root;
                            n_lvl = TOP_LVL;
                            n_erasing = 1'b1;
                            n_size = CW'(r_size - 1'b1);
                        end
                    end else if (c_e == NIL) begin
                        if (r_op == xbt_pkg::OP_ERASE) n_status = xbt_pkg::ST_ERASE_ABSENT;
                        n_state = S_DONE;
                    end else begin
                        nd_rd_en = 1'b1;
                        n_node = c_e;
                        n_lvl = LW'(r_lvl - 1'b1);
                    end
                end else if (r_op == xbt_pkg::OP_COUNT_LT || r_op == xbt_pkg::OP_COUNT_LE) begin
                    n_sum = sum_now;
                    n_addp = vb;
                    n_pcnt = cur_cnt;
                    if (r_lvl == '0) begin
                        n_rcnt = sum_now;
                        n_state = S_DONE;
                    end else if (c_e == NIL) begin
                        n_rcnt = vb ? CW'(sum_now + cur_cnt) : sum_now;
                        n_state = S_DONE;
                    end else begin
                        nd_rd_en = 1'b1;
                        n_node = c_e;
                        n_lvl = LW'(r_lvl - 1'b1);
                    end
                end else if (r_op == xbt_pkg::OP_KTH) begin
                    if (r_probe) begin
                        n_probe = 1'b0;
                        n_lvl = LW'(r_lvl - 1'b1);
                        if (r_k >= KW'(cur_cnt)) begin
                            n_k = KW'(r_k - KW'(cur_cnt));
                            n_res = r_res | bit1;
                            nd_rd_en = 1'b1;
                            nd_rd_addr = r_alt;
                            n_node = r_alt;
                        end
                    end else if (r_lvl == '0) begin
                        n_state = S_DONE;
                    end else if (c0 == NIL) begin
                        n_res = r_res | bit1;
                        nd_rd_en = 1'b1;
                        nd_rd_addr = c1;
                        n_node = c1;
                        n_lvl = LW'(r_lvl - 1'b1);
                    end else begin
                        nd_rd_en = 1'b1;
                        nd_rd_addr = c0;
                        n_node = c0;
                        n_alt = c1;
                        n_probe = 1'b1;
                    end
                end else begin
                    if (r_lvl == '0) begin
                        n_state = S_DONE;
                    end else begin
                        nd_rd_en = 1'b1;
                        n_lvl = LW'(r_lvl - 1'b1);
                        if (c_e == NIL) begin
                            nd_rd_addr = c_o;
                            n_node = c_o;
                            if (!vb) n_res = r_res | bit1;
                        end else begin
                            n_node = c_e;
                            if (vb) n_res = r_res | bit1;
                        end
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.result_value = 32'(r_res);
                    n_out.result_count = 11'(r_rcnt);
                    n_out.element_count = 11'(r_size);
                    n_out.status = r_status;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nd_wr_en) m_node[nd_wr_addr[AW-1:0]] <= nd_wr_data;
        if (nd_rd_en) r_rd_data <= m_node[nd_rd_addr[AW-1:0]];
        if (fl_wr_en) m_free[r_top[AW-1:0]] <= fl_wr_data;
        if (fl_rd_en) r_fl_data <= m_free[alloc_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_size      <= '0;
            r_root      <= NIL;
            r_top       <= NIL;
            r_min_top   <= NIL;
            r_out_valid <= 1'b0;
            r_fresh     <= 1'b0;
            r_probe     <= 1'b0;
            r_addp      <= 1'b0;
            r_erasing   <= 1'b0;
            r_pw        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_size      <= n_size;
            r_root      <= n_root;
            r_top       <= n_top;
            r_min_top   <= n_min_top;
            r_out_valid <= n_out_valid;
            r_fresh     <= n_fresh;
            r_probe     <= n_probe;
            r_addp      <= n_addp;
            r_erasing   <= n_erasing;
            r_pw        <= n_pw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_v      <= n_v;
        r_res    <= n_res;
        r_k      <= n_k;
        r_rcnt   <= n_rcnt;
        r_sum    <= n_sum;
        r_status <= n_status;
        r_lvl    <= n_lvl;
        r_node   <= n_node;
        r_alt    <= n_alt;
        r_ps     <= n_ps;
        r_paddr  <= n_paddr;
        r_pcnt   <= n_pcnt;
        r_pch0   <= n_pch0;
        r_pch1   <= n_pch1;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- test/tb_top.sv -----
module tb_top;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    xbt_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    xbt_pkg::t_out_beat out_data;

    always #6 clk = ~clk;

    xor_binary_trie_multiset dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // multiset kept as stored keys; element = key ^ xor_mask
    logic [31:0]        set_keys[$];
    logic [31:0]        xor_mask = '0;
    xbt_pkg::t_out_beat pending_results[$];
    int                 n_errors = 0;
    int                 n_beats_in = 0;
    int                 n_beats_out = 0;
    bit                 idle_on = 1'b0;
    int                 hold_cycles = 0;
    int                 stall_burst = 0;

    function automatic xbt_pkg::t_out_beat trie_eval(xbt_pkg::t_in_beat b);
        xbt_pkg::t_out_beat r;
        logic [31:0]        v;
        logic [31:0]        e;
        logic [31:0]        elems[$];
        logic [31:0]        best;
        int                 hit;
        r = '0;
        v = b.operand_value;
        hit = -1;
        foreach (set_keys[i]) elems.push_back(set_keys[i] ^ xor_mask);
        case (b.opcode)
            xbt_pkg::OP_INSERT: begin
                if (set_keys.size() >= xbt_pkg::CAPACITY_DEF) r.status = xbt_pkg::ST_SET_FULL;
                else set_keys.push_back(v ^ xor_mask);
            end
            xbt_pkg::OP_ERASE: begin
                foreach (set_keys[i]) if (hit < 0 && set_keys[i] == (v ^ xor_mask)) hit = i;
                if (hit < 0) r.status = xbt_pkg::ST_ERASE_ABSENT;
                else set_keys.delete(hit);
            end
            xbt_pkg::OP_XOR_ALL: xor_mask = xor_mask ^ v;
            xbt_pkg::OP_MIN_XOR, xbt_pkg::OP_MAX_XOR: begin
                if (elems.size() == 0) r.status = xbt_pkg::ST_SET_EMPTY;
                else begin
                    best = elems[0];
                    foreach (elems[i]) begin
                        e = elems[i];
                        if (b.opcode == xbt_pkg::OP_MIN_XOR ? ((e ^ v) < (best ^ v))
                                                            : ((e ^ v) > (best ^ v)))
                            best = e;
                    end
                    r.result_value = best;
                end
            end
            xbt_pkg::OP_KTH: begin
                if (elems.size() == 0) r.status = xbt_pkg::ST_SET_EMPTY;
                else if (b.rank_index >= elems.size()) r.status = xbt_pkg::ST_RANK_RANGE;
                else begin
                    elems.sort();
                    r.result_value = elems[b.rank_index];
                end
            end
            xbt_pkg::OP_COUNT_LT: foreach (elems[i]) if (elems[i] < v) r.result_count++;
            xbt_pkg::OP_COUNT_LE: foreach (elems[i]) if (elems[i] <= v) r.result_count++;
            xbt_pkg::OP_COUNT_EQ: foreach (elems[i]) if (elems[i] == v) r.result_count++;
            default: ;
        endcase
        r.element_count = 11'(set_keys.size());
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            pending_results.push_back(trie_eval(in_data));
            n_beats_in++;
        end
    end

    always @(posedge clk) begin
        xbt_pkg::t_out_beat x;
        if (rst_n && out_valid && !out_stall) begin
            n_beats_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                x = pending_results.pop_front();
                if (out_data.result_value !== x.result_value) begin
                    $error("result_value exp %h got %h", x.result_value,
                           out_data.result_value);
                    n_errors++;
                end
                if (out_data.result_count !== x.result_count) begin
                    $error("result_count exp %0d got %0d", x.result_count,
                           out_data.result_count);
                    n_errors++;
                end
                if (out_data.element_count !== x.element_count) begin
                    $error("element_count exp %0d got %0d", x.element_count,
                           out_data.element_count);
                    n_errors++;
                end
                if (out_data.status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, out_data.status);
                    n_errors++;
                end
            end
        end
    end

    // receiver stall: forced hold, random bursts, random single stalls, or none
    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_burst > 0) begin
            out_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if (!idle_on) begin
            out_stall <= 1'b0;
        end else if (r < 3) begin
            out_stall <= 1'b1;
            stall_burst <= $urandom_range(10, 50);
        end else begin
            out_stall <= (r < 28);
        end
    end

    task automatic send_beat(logic [3:0] op, logic [31:0] v, logic [9:0] k);
        int r;
        in_data <= '{opcode: op, operand_value: v, rank_index: k};
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        r = $urandom_range(0, 99);
        if (idle_on && r >= 60) begin
            in_valid <= 1'b0;
            repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic test_directed;
        send_beat(xbt_pkg::OP_MIN_XOR, 32'h0, 0);
        send_beat(xbt_pkg::OP_MAX_XOR, 32'hFFFF_FFFF, 0);
        send_beat(xbt_pkg::OP_KTH, 32'h0, 0);
        send_beat(xbt_pkg::OP_ERASE, 32'h5, 0);
        send_beat(xbt_pkg::OP_COUNT_LE, 32'hFFFF_FFFF, 0);
        send_beat(xbt_pkg::OP_INSERT, 32'h0, 0);
        send_beat(xbt_pkg::OP_INSERT, 32'hFFFF_FFFF, 0);
        send_beat(xbt_pkg::OP_INSERT, 32'h1234_5678, 0);
        send_beat(xbt_pkg::OP_INSERT, 32'h1234_5678, 0);
        send_beat(xbt_pkg::OP_MIN_XOR, 32'hFFFF_FFF0, 0);
        send_beat(xbt_pkg::OP_MAX_XOR, 32'h0, 0);
        send_beat(xbt_pkg::OP_KTH, 32'h0, 10'd2);
        send_beat(xbt_pkg::OP_KTH, 32'h0, 10'd4);
        send_beat(xbt_pkg::OP_KTH, 32'h0, 10'h3FF);
        send_beat(xbt_pkg::OP_COUNT_LT, 32'hFFFF_FFFF, 0);
        send_beat(xbt_pkg::OP_COUNT_LE, 32'hFFFF_FFFF, 0);
        send_beat(xbt_pkg::OP_COUNT_EQ, 32'h1234_5678, 0);
        send_beat(xbt_pkg::OP_XOR_ALL, 32'hA5A5_0F0F, 0);
        send_beat(xbt_pkg::OP_COUNT_EQ, 32'hA5A5_0F0F, 0);
        send_beat(xbt_pkg::OP_ERASE, 32'hA5A5_0F0F, 0);
        send_beat(xbt_pkg::OP_ERASE, 32'hA5A5_0F0F, 0);
        send_beat(4'd9, 32'hFFFF_FFFF, 10'h3FF);
        send_beat(4'd15, 32'h0, 0);
        send_beat(xbt_pkg::OP_KTH, 32'h0, 10'd0);
        drain();
    endtask

    task automatic test_pressure;
        hold_cycles = 400;
        repeat (20) send_beat(4'($urandom_range(0, 8)), $urandom, 10'($urandom_range(0, 3)));
        drain();
    endtask

    task automatic test_random(int n_items);
        int          r;
        logic [31:0] v;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            v = $urandom;
            if (set_keys.size() != 0 && $urandom_range(0, 1))
                v = set_keys[$urandom_range(0, set_keys.size() - 1)] ^ xor_mask;
            if (r < 30) send_beat(xbt_pkg::OP_INSERT, v, 0);
            else if (r < 55) send_beat(xbt_pkg::OP_ERASE, v, 0);
            else if (r < 62) send_beat(xbt_pkg::OP_XOR_ALL, $urandom, 0);
            else if (r < 96) send_beat(4'($urandom_range(3, 8)), v,
                                       10'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, set_keys.size())));
            else send_beat(4'($urandom_range(9, 15)), $urandom,
                           10'($urandom_range(0, 1023)));
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_on = 1'b1;
        test_pressure();
        test_random(150);
        test_random(300);
        $display("Covered every opcode, empty/absent/range cases, unknown opcodes, xor masks");
        $display("and %0d beats in / %0d out under random gaps and stalls", n_beats_in, n_beats_out);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- xor_binary_trie_multiset.f -----
design/xbt_pkg.sv
design/xor_binary_trie_multiset.sv
test/tb_top.sv
